// File: design/umcd_pkg.sv
// ----------------------------------------------------------------------------
// umcd_pkg
// Shared types and constants for the UART motor command decoder.
// ----------------------------------------------------------------------------
package umcd_pkg;

  localparam int LINE_MAX_DEF = 100;

  localparam logic [15:0] WRAP_RESET = 16'd62500;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [6:0] PCT_FULL = 7'd100;
  localparam logic [7:0] MAG_SAT  = 8'd255;

  // floor(x / 100) == (x * DIV100_RECIP) >> DIV100_SHIFT for x < 2**23
  localparam int          PROD_W       = 23;
  localparam int          RECIP_W      = 24;
  localparam logic [23:0] DIV100_RECIP = 24'd10737419;
  localparam int          DIV100_SHIFT = 30;

  typedef struct packed {
    logic       rev;
    logic [6:0] pct;
  } motor_cap_t;

  typedef struct packed {
    motor_cap_t left;
    motor_cap_t right;
  } cmd_cap_t;

endpackage

// File: design/umcd_if.sv
// ----------------------------------------------------------------------------
// umcd_rx_if / umcd_cmd_if
// Valid/ready channels for received bytes and decoded motor commands.
// ----------------------------------------------------------------------------
interface umcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface umcd_cmd_if;
  logic        valid;
  logic        ready;
  logic        left_reverse;
  logic [15:0] left_level;
  logic        right_reverse;
  logic [15:0] right_level;

  modport source (
    output valid, output left_reverse, output left_level,
    output right_reverse, output right_level, input ready
  );
  modport sink (
    input valid, input left_reverse, input left_level,
    input right_reverse, input right_level, output ready
  );
endinterface

// File: design/umcd_parser.sv
// ----------------------------------------------------------------------------
// umcd_parser
// Per-byte "(a,b)" line parser; captures clipped powers at end of line.
// ----------------------------------------------------------------------------
module umcd_parser #(
  parameter int LineMax = umcd_pkg::LINE_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  umcd_rx_if.sink           rx,
  output logic              cap_valid,
  output umcd_pkg::cmd_cap_t cap,
  input  logic              cap_take
);
  import umcd_pkg::*;

  localparam int CntW = $clog2(LineMax + 1);

  typedef enum logic [2:0] {
    P_OPEN, P_PRE1, P_INT1, P_COMMA, P_PRE2, P_INT2, P_DONE, P_FAIL
  } phase_t;

  phase_t            phase, phase_next;
  logic [CntW-1:0]   count;
  logic              digit_seen, digit_seen_next;
  logic              neg1, neg1_next, neg2, neg2_next;
  logic [7:0]        mag1, mag1_next, mag2, mag2_next;

  logic              accept, line_end, found, is_digit, is_blank, is_sign, is_minus;
  logic [3:0]        dval;
  logic [7:0]        mag_sel, mag_add;
  logic [11:0]       mag_wide;

  function automatic motor_cap_t clip(input logic neg, input logic [7:0] mag);
    logic [6:0] m;
    motor_cap_t r;
    m = (mag > 8'(PCT_FULL)) ? PCT_FULL : mag[6:0];
    if (neg && (m != 7'd0)) begin
      r.rev = 1'b1;
      r.pct = PCT_FULL - m;
    end else begin
      r.rev = 1'b0;
      r.pct = m;
    end
    return r;
  endfunction

  assign rx.ready = !cap_valid || cap_take;
  assign accept   = rx.valid && rx.ready;
  assign line_end = (rx.rx_byte == CH_CR) || (rx.rx_byte == CH_LF)
                    || (count == CntW'(LineMax));
  assign found    = (phase == P_DONE) || ((phase == P_INT2) && digit_seen);

  assign is_digit = (rx.rx_byte >= CH_ZERO) && (rx.rx_byte <= CH_NINE);
  assign is_blank = (rx.rx_byte == CH_SPACE) || (rx.rx_byte == CH_TAB)
                    || (rx.rx_byte == CH_VT) || (rx.rx_byte == CH_FF)
                    || (rx.rx_byte == CH_CR) || (rx.rx_byte == CH_LF);
  assign is_minus = (rx.rx_byte == CH_MINUS);
  assign is_sign  = is_minus || (rx.rx_byte == CH_PLUS);
  assign dval     = 4'(rx.rx_byte - CH_ZERO);

  // One decimal digit into whichever integer is active, saturating at 255
  assign mag_sel  = ((phase == P_PRE2) || (phase == P_INT2)) ? mag2 : mag1;
  assign mag_wide = 12'(mag_sel) * 12'd10 + 12'(dval);
  assign mag_add  = (mag_wide > 12'(MAG_SAT)) ? MAG_SAT : mag_wide[7:0];

  always_comb begin
    phase_next      = phase;
    digit_seen_next = digit_seen;
    neg1_next       = neg1;
    neg2_next       = neg2;
    mag1_next       = mag1;
    mag2_next       = mag2;
    if ((phase != P_DONE) && (phase != P_FAIL)) begin
      if (rx.rx_byte == CH_NUL) begin
        phase_next = ((phase == P_INT2) && digit_seen) ? P_DONE : P_FAIL;
      end else begin
        unique case (phase)
          P_OPEN: begin
            phase_next = (rx.rx_byte == CH_OPEN) ? P_PRE1 : P_FAIL;
          end
          P_PRE1, P_PRE2: begin
            if (is_blank) begin
              phase_next = phase;
            end else if (is_sign) begin
              if (phase == P_PRE2) neg2_next = is_minus;
              else neg1_next = is_minus;
              phase_next = (phase == P_PRE2) ? P_INT2 : P_INT1;
            end else if (is_digit) begin
              if (phase == P_PRE2) mag2_next = mag_add;
              else mag1_next = mag_add;
              digit_seen_next = 1'b1;
              phase_next = (phase == P_PRE2) ? P_INT2 : P_INT1;
            end else begin
              phase_next = P_FAIL;
            end
          end
          P_INT1: begin
            if (is_digit) begin
              mag1_next       = mag_add;
              digit_seen_next = 1'b1;
            end else if (digit_seen) begin
              digit_seen_next = 1'b0;
              phase_next = (rx.rx_byte == CH_COMMA) ? P_PRE2 : P_FAIL;
            end else begin
              phase_next = P_FAIL;
            end
          end
          P_COMMA: begin
            phase_next = (rx.rx_byte == CH_COMMA) ? P_PRE2 : P_FAIL;
          end
          P_INT2: begin
            if (is_digit) begin
              mag2_next       = mag_add;
              digit_seen_next = 1'b1;
            end else begin
              phase_next = digit_seen ? P_DONE : P_FAIL;
            end
          end
          default: phase_next = P_FAIL;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= P_OPEN;
      count      <= '0;
      digit_seen <= 1'b0;
      neg1       <= 1'b0;
      neg2       <= 1'b0;
      mag1       <= '0;
      mag2       <= '0;
      cap_valid  <= 1'b0;
    end else begin
      if (cap_take) cap_valid <= 1'b0;
      if (accept) begin
        if (line_end) begin
          // drop the terminating byte, emit if both integers were read
          if (found) begin
            cap_valid <= 1'b1;
            cap.left  <= clip(neg1, mag1);
            cap.right <= clip(neg2, mag2);
          end
          phase      <= P_OPEN;
          count      <= '0;
          digit_seen <= 1'b0;
          neg1       <= 1'b0;
          neg2       <= 1'b0;
          mag1       <= '0;
          mag2       <= '0;
        end else begin
          count      <= CntW'(count + 1'b1);
          phase      <= phase_next;
          digit_seen <= digit_seen_next;
          neg1       <= neg1_next;
          neg2       <= neg2_next;
          mag1       <= mag1_next;
          mag2       <= mag2_next;
        end
      end
    end
  end

endmodule

// File: design/umcd_scale.sv
// ----------------------------------------------------------------------------
// umcd_scale
// Scales captured powers to PWM levels: wrap * pct, then divide by 100.
// ----------------------------------------------------------------------------
module umcd_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               cap_valid,
  input  umcd_pkg::cmd_cap_t cap,
  output logic               cap_take,
  umcd_cmd_if.source         cmd
);
  import umcd_pkg::*;

  localparam int FullW = PROD_W + RECIP_W;

  logic [15:0]       pwm_wrap;
  logic              prod_valid;
  logic              rev_l, rev_r;
  logic [PROD_W-1:0] prod_l, prod_r;
  logic              out_free, prod_free;
  logic [FullW-1:0]  full_l, full_r;

  assign out_free  = !cmd.valid || cmd.ready;
  assign prod_free = !prod_valid || out_free;
  assign cap_take  = prod_free;

  // reciprocal multiply stands in for the divide by 100
  assign full_l = FullW'(prod_l) * FullW'(DIV100_RECIP);
  assign full_r = FullW'(prod_r) * FullW'(DIV100_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_wrap   <= WRAP_RESET;
      prod_valid <= 1'b0;
      cmd.valid  <= 1'b0;
    end else begin
      if (cfg_we) pwm_wrap <= cfg_wdata;
      if (prod_free) begin
        prod_valid <= cap_valid;
        rev_l      <= cap.left.rev;
        rev_r      <= cap.right.rev;
        prod_l     <= PROD_W'(pwm_wrap * 23'(cap.left.pct));
        prod_r     <= PROD_W'(pwm_wrap * 23'(cap.right.pct));
      end
      if (out_free) begin
        cmd.valid         <= prod_valid;
        cmd.left_reverse  <= rev_l;
        cmd.right_reverse <= rev_r;
        cmd.left_level    <= full_l[DIV100_SHIFT +: 16];
        cmd.right_level   <= full_r[DIV100_SHIFT +: 16];
      end
    end
  end

endmodule

// File: design/uart_motor_command_decoder_unit.sv
// ----------------------------------------------------------------------------
// uart_motor_command_decoder_unit
// A line-ending byte fills the capture register, then the product register, and
// then the output register, which raises cmd.valid.
// Throughput: one byte per cycle; a byte stalls only while all three stages
// (capture, product, output register) are full and the result is not taken.
// Reset clears the line parser and all stage valids; pwm_wrap returns to 62500.
// ----------------------------------------------------------------------------
module uart_motor_command_decoder_unit #(
  parameter int LineMax = umcd_pkg::LINE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  umcd_rx_if.sink     rx,
  umcd_cmd_if.source  cmd,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import umcd_pkg::*;

  logic     cap_valid;
  logic     cap_take;
  cmd_cap_t cap;

  umcd_parser #(
    .LineMax (LineMax)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cap_valid (cap_valid),
    .cap       (cap),
    .cap_take  (cap_take)
  );

  umcd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cap_valid (cap_valid),
    .cap       (cap),
    .cap_take  (cap_take),
    .cmd       (cmd)
  );

endmodule

// File: sim/uart_motor_command_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// uart_motor_command_decoder_unit_test
// Streams command lines, broken lines, noise and overlong lines into the byte
// channel. A line parser kept in the bench predicts every motor command, and
// each command beat is checked against it field by field. Both channels stall
// at random, and the run steps through several pwm_wrap settings.
// ----------------------------------------------------------------------------
module uart_motor_command_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import umcd_pkg::*;

  localparam int         LONG_HOLD    = 300;
  localparam int         QUIET_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         PRINT_CAP    = 40;
  localparam logic [7:0] CH_CLOSE     = 8'h29;

  typedef struct packed {
    logic        l_rev;
    logic [15:0] l_lvl;
    logic        r_rev;
    logic [15:0] r_lvl;
  } motor_cmd_t;

  // Line parser and store of predicted commands.
  class motor_cmd_predictor;
    typedef enum logic [2:0] {
      P_OPEN, P_PRE_A, P_NUM_A, P_COMMA, P_PRE_B, P_NUM_B, P_DONE, P_FAIL
    } parse_e;

    logic [15:0]  wrap;
    int unsigned  held;
    parse_e       phase;
    bit           digit_seen;
    bit           neg_a;
    bit           neg_b;
    logic [7:0]   mag_a;
    logic [7:0]   mag_b;
    motor_cmd_t   pending_cmds[$];
    int           errors;
    int           checked;
    int           lines;

    function new();
      wrap = WRAP_RESET;
      errors = 0;
      checked = 0;
      lines = 0;
      clear_line();
    endfunction

    function void clear_line();
      held = 0;
      phase = P_OPEN;
      digit_seen = 1'b0;
      neg_a = 1'b0;
      neg_b = 1'b0;
      mag_a = '0;
      mag_b = '0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF ||
             c == CH_CR || c == CH_LF;
    endfunction

    function logic [7:0] add_digit(logic [7:0] mag, logic [7:0] c);
      int unsigned v;
      v = mag * 10 + (c - CH_ZERO);
      return (v > MAG_SAT) ? MAG_SAT : v[7:0];
    endfunction

    function void parse_char(logic [7:0] c);
      bit digit;
      digit = (c >= CH_ZERO && c <= CH_NINE);
      if (phase == P_DONE || phase == P_FAIL) return;
      // NUL ends the text: a second integer in progress is complete
      if (c == CH_NUL) begin
        phase = (phase == P_NUM_B && digit_seen) ? P_DONE : P_FAIL;
        return;
      end
      case (phase)
        P_OPEN: phase = (c == CH_OPEN) ? P_PRE_A : P_FAIL;
        P_PRE_A, P_PRE_B: begin
          if (!is_blank(c)) begin
            if (c == CH_MINUS || c == CH_PLUS) begin
              if (phase == P_PRE_B) neg_b = (c == CH_MINUS);
              else neg_a = (c == CH_MINUS);
              phase = (phase == P_PRE_B) ? P_NUM_B : P_NUM_A;
            end else if (digit) begin
              if (phase == P_PRE_B) mag_b = add_digit(mag_b, c);
              else mag_a = add_digit(mag_a, c);
              digit_seen = 1'b1;
              phase = (phase == P_PRE_B) ? P_NUM_B : P_NUM_A;
            end else begin
              phase = P_FAIL;
            end
          end
        end
        P_NUM_A: begin
          if (digit) begin
            mag_a = add_digit(mag_a, c);
            digit_seen = 1'b1;
          end else if (digit_seen) begin
            digit_seen = 1'b0;
            phase = (c == CH_COMMA) ? P_PRE_B : P_FAIL;
          end else begin
            phase = P_FAIL;
          end
        end
        P_COMMA: phase = (c == CH_COMMA) ? P_PRE_B : P_FAIL;
        P_NUM_B: begin
          if (digit) begin
            mag_b = add_digit(mag_b, c);
            digit_seen = 1'b1;
          end else begin
            phase = digit_seen ? P_DONE : P_FAIL;
          end
        end
        default: phase = P_FAIL;
      endcase
    endfunction

    // {reverse, level} for one motor
    function logic [16:0] scale(bit neg, logic [7:0] mag);
      int unsigned pct;
      int unsigned q;
      int unsigned lvl;
      pct = (mag > PCT_FULL) ? PCT_FULL : mag;
      q = (neg && pct != 0) ? PCT_FULL - pct : pct;
      lvl = (int'(wrap) * q) / PCT_FULL;
      return {neg && pct != 0, lvl[15:0]};
    endfunction

    // Returns 1 when the byte closes a line that yields a command.
    function bit note_byte(logic [7:0] c);
      motor_cmd_t want;
      bit found;
      if (c != CH_CR && c != CH_LF && held < LINE_MAX_DEF) begin
        held++;
        parse_char(c);
        return 1'b0;
      end
      found = (phase == P_DONE) || (phase == P_NUM_B && digit_seen);
      lines++;
      if (found) begin
        {want.l_rev, want.l_lvl} = scale(neg_a, mag_a);
        {want.r_rev, want.r_lvl} = scale(neg_b, mag_b);
        pending_cmds.push_back(want);
      end
      clear_line();
      return found;
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task compare(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("command %0d %s: got %0d, predicted %0d",
                         checked, field, got, want));
    endtask

    task check_command(motor_cmd_t got);
      motor_cmd_t want;
      if (pending_cmds.size() == 0) begin
        report($sformatf("unpredicted command %0d/%0d %0d/%0d",
                         got.l_rev, got.l_lvl, got.r_rev, got.r_lvl));
        return;
      end
      want = pending_cmds.pop_front();
      checked++;
      compare("left_reverse", 16'(got.l_rev), 16'(want.l_rev));
      compare("left_level", got.l_lvl, want.l_lvl);
      compare("right_reverse", 16'(got.r_rev), 16'(want.r_rev));
      compare("right_level", got.r_lvl, want.r_lvl);
    endtask

    task report_leftovers();
      if (pending_cmds.size() != 0)
        report($sformatf("%0d predicted commands never arrived", pending_cmds.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  umcd_rx_if  rx_ch ();
  umcd_cmd_if cmd_ch ();

  uart_motor_command_decoder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .cmd       (cmd_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  motor_cmd_predictor cmd_pred = new();

  logic [7:0] line_buf[$];
  bit         sender_gaps   = 1'b0;
  bit         recv_gaps     = 1'b0;
  bit         long_hold_req = 1'b0;
  int         bytes_sent    = 0;
  int         wraps_used    = 1;
  int         quiet_cycles  = 0;

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (long_hold_req) begin
          stall_left = LONG_HOLD;
          long_hold_req = 1'b0;
        end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
      if (stall_left > 0) begin
        cmd_ch.ready = 1'b0;
        stall_left--;
      end else begin
        cmd_ch.ready = 1'b1;
      end
    end
  end

  // Command monitor and watchdog.
  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready)
      cmd_pred.check_command({cmd_ch.left_reverse, cmd_ch.left_level,
                              cmd_ch.right_reverse, cmd_ch.right_level});
    if ((rx_ch.valid && rx_ch.ready) || (cmd_ch.valid && cmd_ch.ready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d commands outstanding",
               QUIET_LIMIT, cmd_pred.pending());
      $display("** uart_motor_command_decoder_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      rx_ch.valid = 1'b0;
      rx_ch.rx_byte = 8'($urandom_range(0, 255));
    end
    @(negedge clk);
    rx_ch.valid = 1'b1;
    rx_ch.rx_byte = b;
    do @(posedge clk); while (!rx_ch.ready);
    void'(cmd_pred.note_byte(b));
    bytes_sent++;
  endtask

  task automatic flush_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    line_buf.delete();
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_term();
    return $urandom_range(0, 1) ? CH_CR : CH_LF;
  endfunction

  task automatic send_text(string body, logic [7:0] term);
    add_text(body);
    line_buf.push_back(term);
    flush_line();
  endtask

  // Random integer field: optional blanks, optional sign, 1 to 5 digits.
  function automatic void add_int();
    int n_blank;
    int n_dig;
    int r;
    n_blank = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
    repeat (n_blank) begin
      case ($urandom_range(0, 3))
        0: line_buf.push_back(CH_SPACE);
        1: line_buf.push_back(CH_TAB);
        2: line_buf.push_back(CH_VT);
        default: line_buf.push_back(CH_FF);
      endcase
    end
    r = $urandom_range(0, 2);
    if (r == 1) line_buf.push_back(CH_PLUS);
    if (r == 2) line_buf.push_back(CH_MINUS);
    n_dig = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 5);
    repeat (n_dig) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic void add_command_body();
    line_buf.push_back(CH_OPEN);
    add_int();
    line_buf.push_back(CH_COMMA);
    add_int();
    if ($urandom_range(0, 3) != 0) line_buf.push_back(CH_CLOSE);
    repeat ($urandom_range(0, 9) < 8 ? 0 : $urandom_range(1, 3))
      line_buf.push_back(8'($urandom_range(8'h21, 8'h7e)));
  endfunction

  task automatic send_random_line();
    int kind;
    int pos;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      add_command_body();
    end else if (kind < 82) begin
      // corrupt one byte or cut the line short
      add_command_body();
      pos = $urandom_range(0, line_buf.size() - 1);
      if ($urandom_range(0, 1)) line_buf[pos] = 8'($urandom_range(0, 255));
      else while (line_buf.size() > pos) void'(line_buf.pop_back());
    end else if (kind < 91) begin
      repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 99) begin
      add_command_body();
      line_buf.insert($urandom_range(0, line_buf.size()), CH_NUL);
    end else begin
      // pad the line to LINE_MAX_DEF - 2 up to LINE_MAX_DEF + 3 bytes before its line end
      add_command_body();
      pos = $urandom_range(LINE_MAX_DEF - 2, LINE_MAX_DEF + 3);
      while (line_buf.size() < pos) line_buf.push_back(8'($urandom_range(8'h20, 8'hff)));
    end
    line_buf.push_back(pick_term());
    if ($urandom_range(0, 9) == 0) line_buf.push_back(CH_LF);
    flush_line();
  endtask

  task automatic run_phase(int n_bytes);
    int goal;
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 9) == 0) sender_gaps = !sender_gaps;
      if ($urandom_range(0, 9) == 0) recv_gaps = !recv_gaps;
      send_random_line();
    end
  endtask

  task automatic set_wrap(logic [15:0] w);
    @(negedge clk);
    rx_ch.valid = 1'b0;
    while (cmd_pred.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = w;
    @(negedge clk);
    cfg_we = 1'b0;
    cmd_pred.wrap = w;
    wraps_used++;
  endtask

  task automatic run_directed();
    send_text("(0,0)", CH_LF);
    send_text("(100,-100)", CH_CR);
    send_text("(-100,100)", CH_LF);
    send_text("(-1,1)", CH_LF);
    send_text("(255,-255)", CH_LF);
    send_text("(99999,+7)", CH_CR);
    send_text("( \t+5,\013\014-3", CH_LF);
    send_text("(-0,-0)", CH_LF);
    send_text("(- 5,3)", CH_LF);
    send_text("(7)", CH_LF);
    send_text("(7,)", CH_LF);
    send_text("x(1,2)", CH_LF);
    send_text("(+,3)", CH_LF);
    send_text("(5 ,6)", CH_LF);
    send_text("(12,34)junk", CH_CR);
    send_text("", CH_LF);
    send_text("(3,4)\r", CH_LF);
    // NUL closes a second integer in progress, but not a missing one
    add_text("(1,2");
    line_buf.push_back(CH_NUL);
    send_text("zz", CH_LF);
    add_text("(1,");
    line_buf.push_back(CH_NUL);
    send_text("5)", CH_LF);
    add_text("(12,34)");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h80);
    send_text("", CH_LF);
    // fill the line to the limit; the next byte ends it and is dropped
    add_text("(1,2)");
    repeat (LINE_MAX_DEF - 5) line_buf.push_back(CH_SPACE);
    line_buf.push_back(CH_NINE);
    send_text("", CH_LF);
  endtask

  initial begin : stimulus
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    cmd_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    set_wrap(16'hFFFF);
    run_phase(150);

    // long output stall with the sender offering every cycle
    set_wrap(16'd1);
    sender_gaps = 1'b0;
    long_hold_req = 1'b1;
    repeat (25) begin
      add_command_body();
      line_buf.push_back(pick_term());
      flush_line();
    end
    run_phase(80);

    set_wrap(16'd0);
    run_phase(120);
    set_wrap(16'd100);
    run_phase(120);
    set_wrap(16'($urandom_range(1, 65535)));
    run_phase(150);
    set_wrap(16'($urandom_range(1, 65535)));
    run_phase(150);

    @(negedge clk);
    rx_ch.valid = 1'b0;
    while (cmd_pred.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cmd_pred.report_leftovers();

    $display("Sent %0d bytes in %0d lines; checked %0d motor commands over %0d pwm_wrap values",
             bytes_sent, cmd_pred.lines, cmd_pred.checked, wraps_used);
    $display("Covered signs, blanks, saturation, NUL, broken and overlong lines, long stall");
    if (cmd_pred.errors == 0) begin
      $display("** uart_motor_command_decoder_unit: PASSED **");
    end else begin
      $display("%0d mismatches", cmd_pred.errors);
      $display("** uart_motor_command_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
design/umcd_pkg.sv
design/umcd_if.sv
design/umcd_parser.sv
design/umcd_scale.sv
design/uart_motor_command_decoder_unit.sv
sim/uart_motor_command_decoder_unit_test.sv
